@@ hdl/esp_pkg.sv @@
// ----------------------------------------------------------------------------
// esp_pkg
// shared types and constants of the expanding shell particle push block
// ----------------------------------------------------------------------------
package esp_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_RADIUS   = 3'd3;
    localparam logic [2:0] REG_FORCE    = 3'd4;
    localparam logic [2:0] REG_DURATION = 3'd5;

    localparam logic [14:0] RADIUS_RESET   = 15'd16384;
    localparam logic [15:0] FORCE_RESET    = 16'd256;
    localparam logic [15:0] DURATION_RESET = 16'd64;

    // item kinds
    localparam logic OPER_TICK     = 1'b0;
    localparam logic OPER_PARTICLE = 1'b1;

    // datapath commands
    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_DEAD  = 4'd2;
    localparam logic [3:0] OP_TDEC  = 4'd3;
    localparam logic [3:0] OP_TMUL  = 4'd4;
    localparam logic [3:0] OP_TDIV  = 4'd5;
    localparam logic [3:0] OP_TSQI  = 4'd6;
    localparam logic [3:0] OP_TSQO  = 4'd7;
    localparam logic [3:0] OP_SQ    = 4'd8;
    localparam logic [3:0] OP_PUSH  = 4'd9;
    localparam logic [3:0] OP_SQRT  = 4'd10;
    localparam logic [3:0] OP_DIV   = 4'd11;
    localparam logic [3:0] OP_NWR   = 4'd12;
    localparam logic [3:0] OP_SUM   = 4'd13;
    localparam logic [3:0] OP_NZERO = 4'd14;

    localparam int SQRT_IN_W = 50;
    localparam int SQRT_W    = 25;
    localparam int DIV_NUM_W = 39;
    localparam int DIV_DEN_W = 25;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tick;
        logic rem_zero;
        logic hit;
        logic sqrt_done;
        logic div_done;
        logic sum_zero;
    } t_dp_stat;

endpackage

@@ hdl/esp_isqrt.sv @@
// ----------------------------------------------------------------------------
// esp_isqrt
// floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
module esp_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [esp_pkg::SQRT_IN_W-1:0] i_val,
    output logic [esp_pkg::SQRT_W-1:0]    o_root,
    output logic                          o_done
);
    import esp_pkg::*;

    logic [SQRT_IN_W-1:0] r_val;
    logic [SQRT_W+1:0]    r_rem;
    logic [SQRT_W-1:0]    r_root;
    logic [4:0]           r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [SQRT_W+2:0]    tr;
    logic [SQRT_W+2:0]    tt;

    assign tr = {r_rem[SQRT_W:0], r_val[SQRT_IN_W-1 -: 2]};
    assign tt = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(SQRT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[SQRT_IN_W-3:0], 2'b00};
            if (tr >= tt) begin
                r_rem  <= (SQRT_W+2)'(tr - tt);
                r_root <= {r_root[SQRT_W-2:0], 1'b1};
            end else begin
                r_rem  <= (SQRT_W+2)'(tr);
                r_root <= {r_root[SQRT_W-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

@@ hdl/esp_div.sv @@
// ----------------------------------------------------------------------------
// esp_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module esp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [esp_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [esp_pkg::DIV_DEN_W-1:0] i_den,
    output logic [esp_pkg::DIV_NUM_W-1:0] o_quo,
    output logic                          o_done
);
    import esp_pkg::*;

    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [5:0]           r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_DEN_W:0]   tr;
    logic                 qbit;

    assign tr   = {r_rem, r_num[DIV_NUM_W-1]};
    assign qbit = (tr >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], qbit};
            r_rem <= qbit ? DIV_DEN_W'(tr - {1'b0, r_den}) : DIV_DEN_W'(tr);
        end
    end

    assign o_quo  = r_num;
    assign o_done = r_done;

endmodule

@@ hdl/esp_dp.sv @@
// ----------------------------------------------------------------------------
// esp_dp
// datapath: burst state, shared multiplier, square root and divider
// ----------------------------------------------------------------------------
module esp_dp #(
    parameter int SHELL_WIDTH = 164
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  esp_pkg::t_dp_cmd       i_cmd,
    output esp_pkg::t_dp_stat      o_stat,
    input  logic                   i_oper,
    input  logic [119:0]           i_word,
    input  logic signed [15:0]     i_center_x,
    input  logic signed [15:0]     i_center_y,
    input  logic signed [15:0]     i_center_z,
    input  logic [14:0]            i_radius,
    input  logic [15:0]            i_force,
    input  logic [15:0]            i_duration,
    input  logic                   i_dur_wr,
    input  logic [15:0]            i_dur_wdata,
    output logic [65:0]            o_result
);
    import esp_pkg::*;

    logic               r_op;
    logic               r_virt;
    logic [15:0]        r_vel;
    logic signed [15:0] r_dir [3];
    logic signed [16:0] r_v   [3];
    logic signed [15:0] r_n   [3];
    logic [33:0]        r_acc;
    logic               r_pushed;
    logic [15:0]        r_rem;
    logic               r_alive;
    logic [31:0]        r_inner;
    logic [31:0]        r_outer;

    logic signed [16:0]   vsel;
    logic [16:0]          mag;
    logic [16:0]          mul_a;
    logic [16:0]          mul_b;
    logic [33:0]          prod;
    logic [14:0]          rq;
    logic [15:0]          ro;
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] quo;
    logic                 div_done;
    logic [SQRT_W-1:0]    root;
    logic                 sqrt_done;
    logic [16:0]          qc;
    logic [15:0]          nval;
    logic [16:0]          vel_sum;
    logic [15:0]          vel_sat;
    logic signed [16:0]   pos [3];
    logic signed [16:0]   ctr [3];

    assign vsel = r_v[i_cmd.idx];
    assign mag  = vsel[16] ? 17'(-vsel) : 17'(vsel);

    // operand select for the shared multiplier
    always_comb begin
        case (i_cmd.op)
            OP_TMUL: begin
                mul_a = {1'b0, i_duration - r_rem};
                mul_b = {2'b00, i_radius};
            end
            OP_TSQI: begin
                mul_a = {2'b00, rq};
                mul_b = {2'b00, rq};
            end
            OP_TSQO: begin
                mul_a = {1'b0, ro};
                mul_b = {1'b0, ro};
            end
            default: begin
                mul_a = mag;
                mul_b = mag;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    assign rq = (i_duration == 16'd0) ? 15'd0 : quo[14:0];
    assign ro = {1'b0, rq} + 16'(SHELL_WIDTH);

    assign div_start = (i_cmd.op == OP_TDIV) || (i_cmd.op == OP_DIV);
    assign div_num   = (i_cmd.op == OP_TDIV) ? {5'd0, r_acc} : {mag, 22'd0};
    assign div_den   = (i_cmd.op == OP_TDIV) ? {9'd0, i_duration} : root;

    esp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    esp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_SQRT),
        .i_val   ({r_acc, 16'd0}),
        .o_root  (root),
        .o_done  (sqrt_done)
    );

    // clamp the quotient into q2.14 with the sign of the component
    assign qc = (quo > DIV_NUM_W'(32768)) ? 17'd32768 : quo[16:0];
    always_comb begin
        if (vsel[16]) begin
            nval = 16'(-qc);
        end else if (qc > 17'd32767) begin
            nval = 16'd32767;
        end else begin
            nval = qc[15:0];
        end
    end

    assign pos[0] = 17'(signed'(i_word[15:0]));
    assign pos[1] = 17'(signed'(i_word[31:16]));
    assign pos[2] = 17'(signed'(i_word[47:32]));
    assign ctr[0] = 17'(i_center_x);
    assign ctr[1] = 17'(i_center_y);
    assign ctr[2] = 17'(i_center_z);

    // burst state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= DURATION_RESET;
            r_alive <= 1'b1;
            r_inner <= '0;
            r_outer <= '0;
        end else if (i_dur_wr) begin
            r_rem   <= i_dur_wdata;
            r_alive <= 1'b1;
            r_inner <= '0;
            r_outer <= '0;
        end else begin
            case (i_cmd.op)
                OP_DEAD: r_alive <= 1'b0;
                OP_TDEC: r_rem   <= r_rem - 16'd1;
                OP_TSQI: r_inner <= prod[31:0];
                OP_TSQO: r_outer <= prod[31:0];
                default: ;
            endcase
        end
    end

    // item working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_op     <= i_oper;
                r_virt   <= i_word[112];
                r_vel    <= i_word[111:96];
                r_pushed <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                    r_dir[i] <= i_word[48 + 16*i +: 16];
                    r_v[i]   <= pos[i] - ctr[i];
                end
            end
            OP_TMUL: r_acc <= prod;
            OP_SQ: begin
                if (i_cmd.idx == 2'd0) begin
                    r_acc <= prod;
                end else begin
                    r_acc <= r_acc + prod;
                end
            end
            OP_PUSH: r_pushed <= 1'b1;
            OP_NWR:  r_n[i_cmd.idx] <= nval;
            OP_SUM: begin
                for (int i = 0; i < 3; i++) begin
                    r_v[i] <= 17'(r_dir[i]) + 17'(r_n[i]);
                end
            end
            OP_NZERO: begin
                for (int i = 0; i < 3; i++) begin
                    r_n[i] <= '0;
                end
            end
            default: ;
        endcase
    end

    assign o_stat.is_tick   = (r_op == OPER_TICK);
    assign o_stat.rem_zero  = (r_rem == 16'd0);
    assign o_stat.hit       = !r_virt && r_alive && (r_acc > {2'b00, r_inner})
                              && (r_acc < {2'b00, r_outer});
    assign o_stat.sqrt_done = sqrt_done;
    assign o_stat.div_done  = div_done;
    assign o_stat.sum_zero  = (r_v[0] == '0) && (r_v[1] == '0) && (r_v[2] == '0);

    assign vel_sum = {1'b0, r_vel} + {1'b0, i_force};
    assign vel_sat = vel_sum[16] ? 16'hFFFF : vel_sum[15:0];

    // result word: dir x, dir y, dir z, velocity, affected, burst alive
    always_comb begin
        if (r_op == OPER_TICK) begin
            o_result = {r_alive, 65'd0};
        end else if (r_pushed) begin
            o_result = {r_alive, 1'b1, vel_sat, r_n[2], r_n[1], r_n[0]};
        end else begin
            o_result = {r_alive, 1'b0, r_vel, r_dir[2], r_dir[1], r_dir[0]};
        end
    end

endmodule

@@ hdl/esp_ctrl.sv @@
// ----------------------------------------------------------------------------
// esp_ctrl
// sequencer that steps the datapath through one tick or particle item
// ----------------------------------------------------------------------------
module esp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_out_load,
    output esp_pkg::t_dp_cmd  o_cmd,
    input  esp_pkg::t_dp_stat i_stat
);
    import esp_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_TMUL   = 5'd2;
    localparam logic [4:0] S_TDIV   = 5'd3;
    localparam logic [4:0] S_TDWAIT = 5'd4;
    localparam logic [4:0] S_TSQI   = 5'd5;
    localparam logic [4:0] S_TSQO   = 5'd6;
    localparam logic [4:0] S_PSQ    = 5'd7;
    localparam logic [4:0] S_PTEST  = 5'd8;
    localparam logic [4:0] S_NSQRT  = 5'd9;
    localparam logic [4:0] S_NSWAIT = 5'd10;
    localparam logic [4:0] S_NDIV   = 5'd11;
    localparam logic [4:0] S_NDWAIT = 5'd12;
    localparam logic [4:0] S_NWR    = 5'd13;
    localparam logic [4:0] S_NSUM   = 5'd14;
    localparam logic [4:0] S_NCHK   = 5'd15;
    localparam logic [4:0] S_FIN    = 5'd16;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       r_pass;
    logic       n_pass;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pass      = r_pass;
        n_out_valid = r_out_valid && !i_out_ready;
        o_out_load  = 1'b0;
        o_cmd.op    = OP_NOP;
        o_cmd.idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.op = OP_LOAD;
                    n_idx    = 2'd0;
                    n_pass   = 1'b0;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.is_tick) begin
                    if (i_stat.rem_zero) begin
                        o_cmd.op = OP_DEAD;
                        n_state  = S_FIN;
                    end else begin
                        o_cmd.op = OP_TDEC;
                        n_state  = S_TMUL;
                    end
                end else begin
                    n_state = S_PSQ;
                end
            end
            S_TMUL: begin
                o_cmd.op = OP_TMUL;
                n_state  = S_TDIV;
            end
            S_TDIV: begin
                o_cmd.op = OP_TDIV;
                n_state  = S_TDWAIT;
            end
            S_TDWAIT: if (i_stat.div_done) n_state = S_TSQI;
            S_TSQI: begin
                o_cmd.op = OP_TSQI;
                n_state  = S_TSQO;
            end
            S_TSQO: begin
                o_cmd.op = OP_TSQO;
                n_state  = S_FIN;
            end
            S_PSQ: begin
                o_cmd.op = OP_SQ;
                if (r_idx == 2'd2) begin
                    n_idx   = 2'd0;
                    n_state = r_pass ? S_NSQRT : S_PTEST;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            S_PTEST: begin
                if (i_stat.hit) begin
                    o_cmd.op = OP_PUSH;
                    n_state  = S_NSQRT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_NSQRT: begin
                o_cmd.op = OP_SQRT;
                n_state  = S_NSWAIT;
            end
            S_NSWAIT: if (i_stat.sqrt_done) n_state = S_NDIV;
            S_NDIV: begin
                o_cmd.op = OP_DIV;
                n_state  = S_NDWAIT;
            end
            S_NDWAIT: if (i_stat.div_done) n_state = S_NWR;
            S_NWR: begin
                o_cmd.op = OP_NWR;
                if (r_idx == 2'd2) begin
                    n_idx   = 2'd0;
                    n_state = r_pass ? S_FIN : S_NSUM;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_NDIV;
                end
            end
            S_NSUM: begin
                o_cmd.op = OP_SUM;
                n_pass   = 1'b1;
                n_state  = S_NCHK;
            end
            S_NCHK: begin
                if (i_stat.sum_zero) begin
                    o_cmd.op = OP_NZERO;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_PSQ;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= 2'd0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DISP))
        else $error("accepted word did not reach dispatch");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |=> r_out_valid)
        else $error("result load did not raise output valid");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a pending word");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd3)
        else $error("component index out of range");

endmodule

@@ hdl/expanding_shell_particle_push_top.sv @@
// ----------------------------------------------------------------------------
// expanding_shell_particle_push_top
// shockwave shell that bends and speeds up particles it passes over
// ----------------------------------------------------------------------------
// A tick word advances the shell, using the 39-step restoring divider that
// scales the radius by the elapsed fraction. A particle word outside the shell
// (or virtual, or with a dead burst) finishes after the shell test; a pushed
// particle runs two vector normalizations (only one when the pushed direction
// sums to zero), each one square root and three divisions on the shared divider.
// One word is in work at a time; a finished result waits in the output
// register while the next word is accepted. Writing the duration register
// restarts the burst.
module expanding_shell_particle_push_top #(
    parameter int SHELL_WIDTH = 164
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, in_velocity, is_virtual, pad
    input  logic [119:0] i_s_tdata,
    // operation
    input  logic         i_s_tuser,
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // out_dir_x, out_dir_y, out_dir_z, out_velocity, affected, burst_alive, pad
    output logic [71:0]  o_m_tdata,
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import esp_pkg::*;

    logic signed [15:0] r_center_x;
    logic signed [15:0] r_center_y;
    logic signed [15:0] r_center_z;
    logic [14:0]        r_radius;
    logic [15:0]        r_force;
    logic [15:0]        r_duration;
    logic [65:0]        r_out;

    t_dp_cmd     cmd;
    t_dp_stat    stat;
    logic        wr;
    logic        out_load;
    logic [65:0] result;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr      = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius   <= RADIUS_RESET;
            r_force    <= FORCE_RESET;
            r_duration <= DURATION_RESET;
        end else if (wr) begin
            case (reg_idx)
                REG_CENTER_X: r_center_x <= pwdata[15:0];
                REG_CENTER_Y: r_center_y <= pwdata[15:0];
                REG_CENTER_Z: r_center_z <= pwdata[15:0];
                REG_RADIUS:   r_radius   <= pwdata[14:0];
                REG_FORCE:    r_force    <= pwdata[15:0];
                REG_DURATION: r_duration <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_CENTER_X: prdata = {16'd0, r_center_x};
            REG_CENTER_Y: prdata = {16'd0, r_center_y};
            REG_CENTER_Z: prdata = {16'd0, r_center_z};
            REG_RADIUS:   prdata = {17'd0, r_radius};
            REG_FORCE:    prdata = {16'd0, r_force};
            REG_DURATION: prdata = {16'd0, r_duration};
            default:      prdata = '0;
        endcase
    end

    esp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_load  (out_load),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    esp_dp #(
        .SHELL_WIDTH (SHELL_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_oper      (i_s_tuser),
        .i_word      (i_s_tdata),
        .i_center_x  (r_center_x),
        .i_center_y  (r_center_y),
        .i_center_z  (r_center_z),
        .i_radius    (r_radius),
        .i_force     (r_force),
        .i_duration  (r_duration),
        .i_dur_wr    (wr && (reg_idx == REG_DURATION)),
        .i_dur_wdata (pwdata[15:0]),
        .o_result    (result)
    );

    // output word register, loaded when the item is done
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= result;
        end
    end

    assign o_m_tdata = {6'd0, r_out};

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the expanding shell particle push block
// ----------------------------------------------------------------------------
// A directed run goes over the corner cases of the shell. Random phases with
// fresh register settings follow, and most particles in them are aimed at the
// current shell. A bit-exact predictor in a small scoreboard computes each
// expected result word when its input word is accepted.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import esp_pkg::*;

    localparam int SHELL_W = 164;
    // an index that no register answers to
    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam int STALL_LIMIT = 6000;
    localparam int PHASES = 7;
    localparam int PHASE_WORDS = 285;

    typedef struct packed {
        logic               op;
        logic signed [15:0] px, py, pz;
        logic signed [15:0] dx, dy, dz;
        logic [15:0]        vel;
        logic               virt;
    } t_particle_word;

    typedef struct packed {
        logic signed [15:0] dx, dy, dz;
        logic [15:0]        vel;
        logic               hit;
        logic               alive;
    } t_push_result;

    // predictor of the shell state plus the queue of results still owed
    class shell_scoreboard;
        logic signed [15:0] cx, cy, cz;
        logic [14:0] radius;
        logic [15:0] push_f, dur, rem;
        logic        alive;
        logic [31:0] inner_sq, outer_sq;
        longint      ring_r;
        t_push_result owed_q[$];
        int mismatches;

        function new();
            cx = '0; cy = '0; cz = '0;
            radius = RADIUS_RESET;
            push_f = FORCE_RESET;
            dur = DURATION_RESET;
            rem = DURATION_RESET;
            alive = 1'b1;
            inner_sq = '0; outer_sq = '0;
            ring_r = 0;
            mismatches = 0;
        endfunction

        static function longint unsigned root64(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // unit vector in Q2.14, each component saturated
        function void unit_vec(input longint v[3], output longint o[3]);
            longint unsigned m[3], sq, len, q;
            longint s;
            sq = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = (v[i] < 0) ? -v[i] : v[i];
                sq += m[i] * m[i];
            end
            len = root64(sq << 16);
            for (int i = 0; i < 3; i++) begin
                q = (len != 0) ? (m[i] << 22) / len : 64'd0;
                if (q > 32768) q = 32768;
                s = (v[i] < 0) ? -longint'(q) : longint'(q);
                if (s > 32767) s = 32767;
                o[i] = s;
            end
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_CENTER_X: cx = value[15:0];
                REG_CENTER_Y: cy = value[15:0];
                REG_CENTER_Z: cz = value[15:0];
                REG_RADIUS:   radius = value[14:0];
                REG_FORCE:    push_f = value[15:0];
                REG_DURATION: begin
                    dur = value[15:0];
                    rem = value[15:0];
                    alive = 1'b1;
                    inner_sq = '0;
                    outer_sq = '0;
                    ring_r = 0;
                end
                default: ;
            endcase
        endfunction

        function void note_word(t_particle_word w);
            t_push_result e;
            longint d[3], dir[3], nd[3], s[3], res[3];
            longint unsigned dsq, r, ro, v;
            e = '0;
            if (w.op == OPER_TICK) begin
                if (rem == 0) begin
                    alive = 1'b0;
                end else begin
                    rem = rem - 16'd1;
                    r = 0;
                    if (dur != 0 && rem <= dur)
                        r = ((64'(dur) - 64'(rem)) * 64'(radius)) / 64'(dur);
                    ro = r + 64'(SHELL_W);
                    ring_r = longint'(r);
                    inner_sq = 32'(r * r);
                    outer_sq = 32'(ro * ro);
                end
                e.alive = alive;
            end else begin
                d[0] = longint'(w.px) - longint'(cx);
                d[1] = longint'(w.py) - longint'(cy);
                d[2] = longint'(w.pz) - longint'(cz);
                dir[0] = longint'(w.dx);
                dir[1] = longint'(w.dy);
                dir[2] = longint'(w.dz);
                dsq = 0;
                for (int i = 0; i < 3; i++) begin
                    dsq += d[i] * d[i];
                    res[i] = dir[i];
                end
                v = {48'd0, w.vel};
                if (!w.virt && alive && dsq > inner_sq && dsq < outer_sq) begin
                    e.hit = 1'b1;
                    unit_vec(d, nd);
                    for (int i = 0; i < 3; i++) s[i] = dir[i] + nd[i];
                    // opposing vectors cancel: direction goes to zero
                    if (s[0] == 0 && s[1] == 0 && s[2] == 0) begin
                        res[0] = 0; res[1] = 0; res[2] = 0;
                    end else begin
                        unit_vec(s, res);
                    end
                    v += {48'd0, push_f};
                    if (v > 16'hFFFF) v = 16'hFFFF;
                end
                e.dx = 16'(res[0]);
                e.dy = 16'(res[1]);
                e.dz = 16'(res[2]);
                e.vel = 16'(v);
                e.alive = alive;
            end
            owed_q.push_back(e);
        endfunction

        function void check_result(logic [71:0] data);
            t_push_result got, exp_r;
            got.dx = data[15:0];
            got.dy = data[31:16];
            got.dz = data[47:32];
            got.vel = data[63:48];
            got.hit = data[64];
            got.alive = data[65];
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", data);
                return;
            end
            exp_r = owed_q.pop_front();
            if (got.dx !== exp_r.dx || got.dy !== exp_r.dy || got.dz !== exp_r.dz ||
                got.vel !== exp_r.vel || got.hit !== exp_r.hit ||
                got.alive !== exp_r.alive) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp dir %0d %0d %0d vel %0d hit %0d alive %0d,",
                              " got dir %0d %0d %0d vel %0d hit %0d alive %0d"},
                             exp_r.dx, exp_r.dy, exp_r.dz, exp_r.vel, exp_r.hit,
                             exp_r.alive, got.dx, got.dy, got.dz, got.vel, got.hit,
                             got.alive);
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_valid;
    logic         o_s_tready;
    // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, in_velocity, is_virtual, pad
    logic [119:0] s_data;
    // operation
    logic         s_user;
    logic         o_m_tvalid;
    logic         m_ready;
    // out_dir_x, out_dir_y, out_dir_z, out_velocity, affected, burst_alive, pad
    logic [71:0]  o_m_tdata;
    logic         psel, penable, pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    shell_scoreboard sb = new();
    bit calm;          // no idling on either side while set
    int words_out;
    int stall_cnt = 0;

    expanding_shell_particle_push_top #(.SHELL_WIDTH(SHELL_W)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit take_gap();
        return !calm && $urandom_range(0, 99) < 28;
    endfunction

    function automatic t_particle_word mk(logic op, int px, int py, int pz,
                                          int dx, int dy, int dz, int vel, logic virt);
        t_particle_word w;
        w.op = op;
        w.px = 16'(px); w.py = 16'(py); w.pz = 16'(pz);
        w.dx = 16'(dx); w.dy = 16'(dy); w.dz = 16'(dz);
        w.vel = 16'(vel);
        w.virt = virt;
        return w;
    endfunction

    // any bit pattern at all
    function automatic t_particle_word noise_word();
        t_particle_word w;
        w.op = 1'($urandom_range(0, 1));
        w.px = 16'($urandom); w.py = 16'($urandom); w.pz = 16'($urandom);
        w.dx = 16'($urandom); w.dy = 16'($urandom); w.dz = 16'($urandom);
        w.vel = 16'($urandom);
        w.virt = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // particle placed at a random bearing just past the current inner radius
    function automatic t_particle_word shell_word();
        t_particle_word w;
        longint v[3], p[3], t, l;
        w = noise_word();
        w.op = OPER_PARTICLE;
        w.virt = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < 3; i++) v[i] = longint'($urandom_range(0, 2000)) - 1000;
        if (v[0] == 0 && v[1] == 0 && v[2] == 0) v[0] = 1;
        l = shell_scoreboard::root64(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
        t = sb.ring_r + longint'($urandom_range(1, SHELL_W - 1));
        p[0] = longint'(sb.cx) + v[0] * t / l;
        p[1] = longint'(sb.cy) + v[1] * t / l;
        p[2] = longint'(sb.cz) + v[2] * t / l;
        for (int i = 0; i < 3; i++) begin
            if (p[i] > 32767) p[i] = 32767;
            if (p[i] < -32768) p[i] = -32768;
        end
        w.px = 16'(p[0]); w.py = 16'(p[1]); w.pz = 16'(p[2]);
        return w;
    endfunction

    task automatic send_word(input t_particle_word w);
        while (take_gap()) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {7'd0, w.virt, w.vel, w.dz, w.dy, w.dx, w.pz, w.py, w.px};
        s_user <= w.op;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_word(w);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // block drained: every owed word is back, plus a margin for the last one
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // receiver: checks words, stalls at random, holds off once for a long stretch
    initial begin
        bit held;
        held = 1'b0;
        words_out = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && m_ready) begin
                sb.check_result(o_m_tdata);
                words_out++;
            end
            if (!held && words_out >= 300) begin
                // block fills up and must back-pressure the sender
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                m_ready <= !take_gap();
            end
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if ((s_valid && o_s_tready) || (o_m_tvalid && m_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        logic [15:0] cx, cy, cz;
        int pick;
        calm = 1'b0;
        i_rst_n <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        s_user <= OPER_TICK;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part, reset registers ----
        // no tick yet: shell is empty, nothing gets pushed
        send_word(mk(OPER_PARTICLE, 100, 0, 0, 1000, 0, 0, 5, 1'b0));
        // first tick puts the shell at 256..420
        send_word(mk(OPER_TICK, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        // extreme direction, speed saturates
        send_word(mk(OPER_PARTICLE, 300, 0, 0, -32768, 32767, -32768, 65535, 1'b0));
        // direction exactly opposite the push: sum is zero
        send_word(mk(OPER_PARTICLE, 300, 0, 0, -16384, 0, 0, 10, 1'b0));
        // virtual particle in the shell stays put
        send_word(mk(OPER_PARTICLE, 300, 0, 0, 100, 200, 300, 10, 1'b1));
        // zero direction, pushed along negative y
        send_word(mk(OPER_PARTICLE, 0, -300, 0, 0, 0, 0, 0, 1'b0));
        // exactly on the inner and the outer boundary: not strictly inside
        send_word(mk(OPER_PARTICLE, 256, 0, 0, 7, 7, 7, 7, 1'b0));
        send_word(mk(OPER_PARTICLE, 0, 0, 420, 7, 7, 7, 7, 1'b0));
        // at the centre
        send_word(mk(OPER_PARTICLE, 0, 0, 0, 7, 7, 7, 7, 1'b0));
        wait_drained();
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        // zero duration: next tick kills the burst
        apb_write(REG_DURATION, 32'd0);
        send_word(mk(OPER_TICK, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_word(mk(OPER_PARTICLE, 0, 0, 0, 1, 1, 1, 1, 1'b0));
        send_word(mk(OPER_TICK, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        wait_drained();
        // full radius in one tick, centre at the negative corner
        apb_write(REG_CENTER_X, 32'h0000_8000);
        apb_write(REG_CENTER_Y, 32'h0000_8000);
        apb_write(REG_CENTER_Z, 32'h0000_8000);
        apb_write(REG_RADIUS, 32'd32767);
        apb_write(REG_DURATION, 32'd1);
        send_word(mk(OPER_TICK, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_word(mk(OPER_PARTICLE, -1, -32768, -32768, 0, 0, 0, 9, 1'b0));
        send_word(mk(OPER_PARTICLE, 0, -32768, -32768, 0, 0, 0, 9, 1'b0));
        send_word(mk(OPER_PARTICLE, 32767, -32768, -32768, 0, 0, 0, 9, 1'b0));
        send_word(mk(OPER_TICK, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        wait_drained();
        // zero radius, longest burst, largest push
        apb_write(REG_CENTER_X, 32'd32767);
        apb_write(REG_CENTER_Y, 32'd0);
        apb_write(REG_CENTER_Z, 32'd0);
        apb_write(REG_RADIUS, 32'd0);
        apb_write(REG_FORCE, 32'd65535);
        apb_write(REG_DURATION, 32'd65535);
        send_word(mk(OPER_TICK, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_word(mk(OPER_PARTICLE, 32667, 0, 0, 0, 32767, 0, 1, 1'b0));
        send_word(mk(OPER_PARTICLE, 32767, 0, 0, 0, 32767, 0, 1, 1'b0));
        wait_drained();

        // ---- random phases ----
        for (int ph = 0; ph < PHASES; ph++) begin
            calm = (ph == 2);
            cx = 16'(int'($urandom_range(0, 16383)) - 8192);
            cy = 16'(int'($urandom_range(0, 16383)) - 8192);
            cz = 16'(int'($urandom_range(0, 16383)) - 8192);
            if (ph == 5) begin
                cx = 16'h7FFF;
                cz = 16'h8000;
            end
            apb_write(REG_CENTER_X, {16'd0, cx});
            apb_write(REG_CENTER_Y, {16'd0, cy});
            apb_write(REG_CENTER_Z, {16'd0, cz});
            apb_write(REG_RADIUS, (ph == 5) ? 32'd32767 : $urandom_range(0, 24000));
            apb_write(REG_FORCE, (ph == 3) ? 32'd0 : $urandom);
            apb_write(REG_DURATION, (ph == 4) ? 32'd65535 : $urandom_range(2, 40));
            for (int n = 0; n < PHASE_WORDS; n++) begin
                pick = int'($urandom_range(0, 99));
                if (pick < 15)
                    send_word(mk(OPER_TICK, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom,
                                 1'($urandom_range(0, 1))));
                else if (pick < 75)
                    send_word(shell_word());
                else
                    send_word(noise_word());
            end
            wait_drained();
        end
        calm = 1'b0;

        repeat (400) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.owed_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
